// ===== hw/rtl/cfd_pkg.sv =====
// Shared types and constants for the complex FIR decimator.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package cfd_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int TAP_W      = 18;
   localparam int PROD_W     = SAMPLE_W + TAP_W;
   localparam int FRAC_W     = 17;
   localparam int DEC_W      = 7;
   localparam int DEC_MAX    = 64;
   localparam int PHASE_W    = 6;
   localparam int TAP_IDX_W  = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Command codes carried by req_cmd
   typedef enum logic {
      CMD_SAMPLE   = 1'b0,
      CMD_LOAD_TAP = 1'b1
   } cmd_type;

   // Register index, taken from paddr bit 2
   localparam logic REG_DECIMATION = 1'b0;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
   } sample_type;

   typedef struct packed {
      logic signed [TAP_W-1:0] re;
      logic signed [TAP_W-1:0] im;
   } tap_type;

   typedef struct packed {
      logic shift;
      logic rotate;
      logic tap_we;
   } cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic feed;
   } mac_ctrl_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] re;
      logic signed [SAMPLE_W-1:0] im;
      logic                       sat;
   } mac_result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/cfd_cell.sv =====
// One cell of the filter chain: holds one delay-line sample and one tap.
// Depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_cell #(
   parameter int unsigned CELL_IDX = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cfd_pkg::cell_ctrl_type              ctrl,
   input  logic [cfd_pkg::TAP_IDX_W-1:0]       tap_index,
   input  cfd_pkg::tap_type                    tap_value,
   input  cfd_pkg::sample_type                 shift_src,
   input  cfd_pkg::sample_type                 rot_sample,
   input  cfd_pkg::tap_type                    rot_tap,
   output cfd_pkg::sample_type                 sample,
   output cfd_pkg::tap_type                    tap
);
   import cfd_pkg::*;

   sample_type sample_ff, sample_in;
   tap_type    tap_ff, tap_in;
   logic       tap_hit;

   assign tap_hit = (32'(tap_index) == CELL_IDX);

   always_comb begin
      sample_in = sample_ff;
      tap_in    = tap_ff;
      if (ctrl.rotate) begin
         // pass both values one place toward the head of the chain
         sample_in = rot_sample;
         tap_in    = rot_tap;
      end else begin
         if (ctrl.shift) begin
            sample_in = shift_src;
         end
         if (ctrl.tap_we && tap_hit) begin
            tap_in = tap_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
         tap_ff    <= '0;
      end else begin
         sample_ff <= sample_in;
         tap_ff    <= tap_in;
      end
   end

   assign sample = sample_ff;
   assign tap    = tap_ff;

endmodule

// ===== hw/rtl/cfd_mac.sv =====
// Complex multiply-accumulate at the head of the chain, with round and saturate.
// Depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_mac #(
   parameter int FIR_SIZE = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfd_pkg::mac_ctrl_type   ctrl,
   input  cfd_pkg::sample_type     sample,
   input  cfd_pkg::tap_type        tap,
   output cfd_pkg::mac_result_type result
);
   import cfd_pkg::*;

   localparam int ACC_W = PROD_W + 1 + $clog2(FIR_SIZE);
   localparam logic signed [ACC_W:0] RND_BIAS = (ACC_W+1)'(1) <<< (FRAC_W - 1);
   localparam logic signed [ACC_W:0] SAT_HI   = (ACC_W+1)'(32767);
   localparam logic signed [ACC_W:0] SAT_LO   = -(ACC_W+1)'(32768);

   logic signed [PROD_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [PROD_W-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_im_ff, acc_re_in, acc_im_in;
   logic signed [ACC_W:0]    q_re, q_im;
   logic                     sat_re, sat_im;

   assign p_rr_in = PROD_W'(sample.re) * PROD_W'(tap.re);
   assign p_ii_in = PROD_W'(sample.im) * PROD_W'(tap.im);
   assign p_ri_in = PROD_W'(sample.re) * PROD_W'(tap.im);
   assign p_ir_in = PROD_W'(sample.im) * PROD_W'(tap.re);

   always_ff @(posedge clock) begin
      p_rr_ff <= p_rr_in;
      p_ii_ff <= p_ii_in;
      p_ri_ff <= p_ri_in;
      p_ir_ff <= p_ir_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.feed;
      end
   end

   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (ctrl.clear) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (prod_vld_ff) begin
         acc_re_in = acc_re_ff + ACC_W'(p_rr_ff) - ACC_W'(p_ii_ff);
         acc_im_in = acc_im_ff + ACC_W'(p_ri_ff) + ACC_W'(p_ir_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
   end

   // round half up, drop the fraction, clip to the sample range
   always_comb begin
      q_re   = ((ACC_W+1)'(acc_re_ff) + RND_BIAS) >>> FRAC_W;
      q_im   = ((ACC_W+1)'(acc_im_ff) + RND_BIAS) >>> FRAC_W;
      sat_re = (q_re > SAT_HI) || (q_re < SAT_LO);
      sat_im = (q_im > SAT_HI) || (q_im < SAT_LO);
      if (q_re > SAT_HI) begin
         result.re = SAT_HI[SAMPLE_W-1:0];
      end else if (q_re < SAT_LO) begin
         result.re = SAT_LO[SAMPLE_W-1:0];
      end else begin
         result.re = q_re[SAMPLE_W-1:0];
      end
      if (q_im > SAT_HI) begin
         result.im = SAT_HI[SAMPLE_W-1:0];
      end else if (q_im < SAT_LO) begin
         result.im = SAT_LO[SAMPLE_W-1:0];
      end else begin
         result.im = q_im[SAMPLE_W-1:0];
      end
      result.sat = sat_re || sat_im;
   end

endmodule

// ===== hw/rtl/complex_fir_decimator_core.sv =====
// Top level of the complex FIR decimator: control, register port, cell chain.
// Depends on cfd_pkg, cfd_cell and cfd_mac.
`timescale 1ns / 1ps

//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------------------
//  req     | in        | req_valid / req_ready    | cmd, sample re/im, tap index, tap re/im
//  rsp     | out       | rsp_valid / rsp_ready    | out re/im, saturated
//  csr     | in/out    | psel, penable, pready    | paddr, pwdata, prdata (decimation)
//
//  A load-tap item or a sample item with no output due is taken in the idle
//  state, which stays ready for the next item. A sample item that completes
//  a decimation period keeps the block busy after its transfer: the chain
//  rotates once through the single complex MAC at its head, then the product
//  and accumulate registers drain. The result then sits in the output register,
//  which stalls the block only if the previous result is still untaken.
//  Synchronous reset clears samples, taps and counters and sets the factor to 1.

module complex_fir_decimator_core #(
   parameter int FIR_SIZE = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input item channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_cmd,
   input  logic signed [cfd_pkg::SAMPLE_W-1:0]    req_sample_re,
   input  logic signed [cfd_pkg::SAMPLE_W-1:0]    req_sample_im,
   input  logic [cfd_pkg::TAP_IDX_W-1:0]          req_tap_index,
   input  logic signed [cfd_pkg::TAP_W-1:0]       req_tap_re,
   input  logic signed [cfd_pkg::TAP_W-1:0]       req_tap_im,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [cfd_pkg::SAMPLE_W-1:0]    rsp_out_re,
   output logic signed [cfd_pkg::SAMPLE_W-1:0]    rsp_out_im,
   output logic                                   rsp_saturated,
   // register port
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [cfd_pkg::CSR_ADDR_W-1:0]         paddr,
   input  logic [cfd_pkg::CSR_DATA_W-1:0]         pwdata,
   output logic [cfd_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);
   import cfd_pkg::*;

   localparam int CNT_W = $clog2(FIR_SIZE);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FIR_SIZE - 1);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [DEC_W-1:0]   dec_ff;
   logic [DEC_W-1:0]   dec_eff;
   logic [DEC_W-1:0]   phase_sum;
   logic               out_due;
   logic               req_xfer;
   logic               is_sample;
   logic               csr_wr;
   logic               rsp_room;
   logic               rsp_load;
   cell_ctrl_type      cell_ctrl;
   mac_ctrl_type       mac_ctrl;
   mac_result_type     mac_res;
   mac_result_type     rsp_ff;
   logic               rsp_valid_ff;
   sample_type         new_sample;
   tap_type            new_tap;
   sample_type         cell_sample [FIR_SIZE];
   tap_type            cell_tap    [FIR_SIZE];

   // ---------------------------------------------------------------------
   // Register port: single decimation register, no wait states
   // ---------------------------------------------------------------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DECIMATION);

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_ff <= DEC_W'(1);
      end else if (csr_wr) begin
         dec_ff <= pwdata[DEC_W-1:0];
      end
   end

   assign prdata = (paddr[2] == REG_DECIMATION) ? CSR_DATA_W'(dec_ff) : '0;

   // clamp the factor: zero acts as one, anything above the maximum as the maximum
   always_comb begin
      if (dec_ff == '0) begin
         dec_eff = DEC_W'(1);
      end else if (dec_ff > DEC_W'(DEC_MAX)) begin
         dec_eff = DEC_W'(DEC_MAX);
      end else begin
         dec_eff = dec_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Phase counter: an output falls due when the count reaches the factor
   // ---------------------------------------------------------------------
   assign req_xfer  = req_valid && req_ready;
   assign is_sample = (req_cmd == CMD_SAMPLE);
   assign phase_sum = DEC_W'(phase_ff) + DEC_W'(1);
   assign out_due   = (phase_sum >= dec_eff);

   always_comb begin
      phase_in = phase_ff;
      if (req_xfer && is_sample) begin
         phase_in = out_due ? '0 : phase_sum[PHASE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: accept, rotate the chain once through the MAC, drain, deliver
   // ---------------------------------------------------------------------
   assign rsp_room = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cell_ctrl = '0;
      mac_ctrl  = '0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (is_sample) begin
                  // push the new sample in at the head of the delay line
                  cell_ctrl.shift = 1'b1;
                  if (out_due) begin
                     mac_ctrl.clear = 1'b1;
                     cnt_in         = '0;
                     state_in       = ST_RUN;
                  end
               end else begin
                  cell_ctrl.tap_we = 1'b1;
               end
            end
         end
         ST_RUN: begin
            // feed the head cell to the MAC and advance the ring by one
            cell_ctrl.rotate = 1'b1;
            mac_ctrl.feed    = 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            // last product goes into the accumulator
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register has room
            if (rsp_room) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Cell chain: cell i holds x[newest - i] and tap[i]
   // ---------------------------------------------------------------------
   assign new_sample = '{re: req_sample_re, im: req_sample_im};
   assign new_tap    = '{re: req_tap_re, im: req_tap_im};

   for (genvar g = 0; g < FIR_SIZE; g++) begin : g_cell
      sample_type shift_src;

      if (g == 0) begin : g_head
         assign shift_src = new_sample;
      end else begin : g_body
         assign shift_src = cell_sample[g-1];
      end

      cfd_cell #(
         .CELL_IDX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .tap_index  (req_tap_index),
         .tap_value  (new_tap),
         .shift_src  (shift_src),
         .rot_sample (cell_sample[(g + 1) % FIR_SIZE]),
         .rot_tap    (cell_tap[(g + 1) % FIR_SIZE]),
         .sample     (cell_sample[g]),
         .tap        (cell_tap[g])
      );
   end

   cfd_mac #(
      .FIR_SIZE (FIR_SIZE)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .sample (cell_sample[0]),
      .tap    (cell_tap[0]),
      .result (mac_res)
   );

   // ---------------------------------------------------------------------
   // Output register: holds a finished result until its transfer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= mac_res;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_re    = rsp_ff.re;
   assign rsp_out_im    = rsp_ff.im;
   assign rsp_saturated = rsp_ff.sat;

endmodule

// ===== tb/fir_output_checker.sv =====
// Result checker for the complex FIR decimator: watches the request, result and
// register ports, predicts every filter output and compares it. Needs cfd_pkg.
`timescale 1ns / 1ps

module fir_output_checker #(
   parameter int TAPS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_cmd,
   input  logic signed [cfd_pkg::SAMPLE_W-1:0] req_sample_re,
   input  logic signed [cfd_pkg::SAMPLE_W-1:0] req_sample_im,
   input  logic [cfd_pkg::TAP_IDX_W-1:0]       req_tap_index,
   input  logic signed [cfd_pkg::TAP_W-1:0]    req_tap_re,
   input  logic signed [cfd_pkg::TAP_W-1:0]    req_tap_im,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [cfd_pkg::SAMPLE_W-1:0] rsp_out_re,
   input  logic signed [cfd_pkg::SAMPLE_W-1:0] rsp_out_im,
   input  logic                                rsp_saturated,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cfd_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [cfd_pkg::CSR_DATA_W-1:0]      pwdata,
   input  logic [cfd_pkg::CSR_DATA_W-1:0]      prdata,
   input  logic                                pready,
   output int                                  mismatch_count,
   output int                                  pending_count
);
   import cfd_pkg::*;

   localparam longint OUT_HI       = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint OUT_LO       = -OUT_HI - 1;
   localparam longint ROUND_HALF   = longint'(1) << (FRAC_W - 1);

   sample_type          sample_ring [TAPS];
   tap_type             tap_bank    [TAPS];
   int unsigned         ring_slot;
   int unsigned         sample_phase;
   logic [DEC_W-1:0]    factor_reg;
   mac_result_type      expected_outputs [$];

   function automatic logic signed [SAMPLE_W-1:0] round_clip(input longint acc,
                                                             output bit hit);
      longint q;
      q   = (acc + ROUND_HALF) >>> FRAC_W;
      hit = 1'b0;
      if (q > OUT_HI) begin
         q   = OUT_HI;
         hit = 1'b1;
      end else if (q < OUT_LO) begin
         q   = OUT_LO;
         hit = 1'b1;
      end
      return q[SAMPLE_W-1:0];
   endfunction

   // Store one sample and, when the decimation period closes, queue the output.
   function automatic void take_sample(input logic signed [SAMPLE_W-1:0] s_re,
                                       input logic signed [SAMPLE_W-1:0] s_im);
      int unsigned    span;
      int unsigned    slot;
      longint         acc_re;
      longint         acc_im;
      bit             hit_re;
      bit             hit_im;
      mac_result_type y;
      span = (factor_reg == 0) ? 1 : ((factor_reg > DEC_MAX) ? DEC_MAX : factor_reg);
      sample_ring[ring_slot].re = s_re;
      sample_ring[ring_slot].im = s_im;
      sample_phase++;
      if (sample_phase < span) begin
         ring_slot = (ring_slot + 1) % TAPS;
         return;
      end
      sample_phase = 0;
      acc_re = 0;
      acc_im = 0;
      for (int i = 0; i < TAPS; i++) begin
         slot = (ring_slot + TAPS - i) % TAPS;
         acc_re += longint'($signed(sample_ring[slot].re)) * longint'($signed(tap_bank[i].re))
                 - longint'($signed(sample_ring[slot].im)) * longint'($signed(tap_bank[i].im));
         acc_im += longint'($signed(sample_ring[slot].re)) * longint'($signed(tap_bank[i].im))
                 + longint'($signed(sample_ring[slot].im)) * longint'($signed(tap_bank[i].re));
      end
      ring_slot = (ring_slot + 1) % TAPS;
      y.re  = round_clip(acc_re, hit_re);
      y.im  = round_clip(acc_im, hit_im);
      y.sat = hit_re | hit_im;
      expected_outputs.push_back(y);
   endfunction

   task automatic compare_field(input string name, input logic signed [SAMPLE_W-1:0] want,
                                input logic signed [SAMPLE_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            sample_ring[i] = '0;
            tap_bank[i]    = '0;
         end
         ring_slot    = 0;
         sample_phase = 0;
         factor_reg   = DEC_W'(1);
         expected_outputs.delete();
      end else begin
         // Results leave before new predictions enter: no result can belong to
         // a request taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_outputs.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, got re %0d im %0d sat %0b",
                        $time, rsp_out_re, rsp_out_im, rsp_saturated);
            end else begin
               mac_result_type want;
               want = expected_outputs.pop_front();
               compare_field("out_re", want.re, rsp_out_re);
               compare_field("out_im", want.im, rsp_out_im);
               compare_field("saturated", SAMPLE_W'(want.sat), SAMPLE_W'(rsp_saturated));
            end
         end
         if (psel && penable && pready && paddr[2] == REG_DECIMATION) begin
            if (pwrite) begin
               factor_reg = pwdata[DEC_W-1:0];
            end else if (prdata !== CSR_DATA_W'(factor_reg)) begin
               mismatch_count++;
               $display("%0t: decimation readback mismatch, expected %0d, got %0d",
                        $time, factor_reg, prdata);
            end
         end
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_LOAD_TAP) begin
               if (req_tap_index < TAPS) begin
                  tap_bank[req_tap_index].re = req_tap_re;
                  tap_bank[req_tap_index].im = req_tap_im;
               end
            end else begin
               take_sample(req_sample_re, req_sample_im);
            end
         end
      end
      pending_count = expected_outputs.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Top of the complex FIR decimator testbench: clock, reset, request and register
// stimulus, result sink and verdict. Needs cfd_pkg, the core and fir_output_checker.
`timescale 1ns / 1ps

module tb_top;
   import cfd_pkg::*;

   localparam int     FIR_TAPS     = 64;
   localparam int     ITEM_TARGET  = 2000;
   localparam int     MAX_GAP      = 16;
   // a full MAC pass plus pipeline drain, with margin
   localparam int     DRAIN_CYCLES = FIR_TAPS + 8;
   localparam int     HOLD_CYCLES  = 400;
   localparam longint RUN_LIMIT_NS = 10_000_000;

   localparam logic [CSR_ADDR_W-1:0] DEC_ADDR   = {REG_DECIMATION, 2'b00};
   // one slot above the last register: writes there must be dropped
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = {~REG_DECIMATION, 2'b00};

   typedef enum {
      TAPS_FULL,
      TAPS_SMALL,
      TAPS_SPARSE
   } tap_shape_type;

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_ready;
   logic                          req_cmd       = CMD_SAMPLE;
   logic signed [SAMPLE_W-1:0]    req_sample_re = '0;
   logic signed [SAMPLE_W-1:0]    req_sample_im = '0;
   logic [TAP_IDX_W-1:0]          req_tap_index = '0;
   logic signed [TAP_W-1:0]       req_tap_re    = '0;
   logic signed [TAP_W-1:0]       req_tap_im    = '0;
   logic                          rsp_valid;
   logic                          rsp_ready     = 1'b0;
   logic signed [SAMPLE_W-1:0]    rsp_out_re;
   logic signed [SAMPLE_W-1:0]    rsp_out_im;
   logic                          rsp_saturated;
   logic                          psel          = 1'b0;
   logic                          penable       = 1'b0;
   logic                          pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0]         paddr         = '0;
   logic [CSR_DATA_W-1:0]         pwdata        = '0;
   logic [CSR_DATA_W-1:0]         prdata;
   logic                          pready;

   int mismatch_count;
   int pending_count;
   int items_sent    = 0;
   // chance in percent that a side idles before its next transfer
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // nonzero: the sink holds rsp_ready low for this many cycles, once
   int recv_hold     = 0;

   always #5 clock = ~clock;

   complex_fir_decimator_core #(
      .FIR_SIZE(FIR_TAPS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_sample_re (req_sample_re),
      .req_sample_im (req_sample_im),
      .req_tap_index (req_tap_index),
      .req_tap_re    (req_tap_re),
      .req_tap_im    (req_tap_im),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_re    (rsp_out_re),
      .rsp_out_im    (rsp_out_im),
      .rsp_saturated (rsp_saturated),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   fir_output_checker #(
      .TAPS(FIR_TAPS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_sample_re  (req_sample_re),
      .req_sample_im  (req_sample_im),
      .req_tap_index  (req_tap_index),
      .req_tap_re     (req_tap_re),
      .req_tap_im     (req_tap_im),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_re     (rsp_out_re),
      .rsp_out_im     (rsp_out_im),
      .rsp_saturated  (rsp_saturated),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Random signed value of the given width; now and then one of its two extremes.
   function automatic logic signed [31:0] rand_signed(input int bits);
      logic signed [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 15))
         0:       return (32'sd1 <<< (bits - 1)) - 1;
         1:       return -(32'sd1 <<< (bits - 1));
         default: return r >>> (32 - bits);
      endcase
   endfunction

   function automatic logic [TAP_W-1:0] pick_tap(input tap_shape_type shape);
      case (shape)
         TAPS_SMALL:  return TAP_W'(rand_signed($urandom_range(6, 14)));
         TAPS_SPARSE: return ($urandom_range(0, 7) == 0) ? TAP_W'(rand_signed(TAP_W)) : '0;
         default:     return TAP_W'(rand_signed(TAP_W));
      endcase
   endfunction

   // Offer one request after a random gap; return once it has been transferred.
   // Valid stays high past the transfer until the next falling edge, where it
   // is either dropped or carries the next item.
   task automatic push_request(input cmd_type cmd,
                               input logic [SAMPLE_W-1:0] s_re, input logic [SAMPLE_W-1:0] s_im,
                               input logic [TAP_IDX_W-1:0] idx,
                               input logic [TAP_W-1:0] t_re, input logic [TAP_W-1:0] t_im);
      int gap;
      gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_sample_re <= s_re;
      req_sample_im <= s_im;
      req_tap_index <= idx;
      req_tap_re    <= t_re;
      req_tap_im    <= t_im;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Fields that the command does not use carry random junk.
   task automatic push_sample(input logic [SAMPLE_W-1:0] re, input logic [SAMPLE_W-1:0] im);
      push_request(CMD_SAMPLE, re, im, TAP_IDX_W'($urandom()),
                   TAP_W'($urandom()), TAP_W'($urandom()));
   endtask

   task automatic push_tap(input logic [TAP_IDX_W-1:0] idx,
                           input logic [TAP_W-1:0] re, input logic [TAP_W-1:0] im);
      push_request(CMD_LOAD_TAP, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()), idx, re, im);
   endtask

   // One register access: setup cycle, then access cycle until pready.
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Upper data bits are random: only the low DEC_W bits belong to the register.
   task automatic set_factor(input int value);
      logic [CSR_DATA_W-1:0] word;
      word            = $urandom();
      word[DEC_W-1:0] = DEC_W'(value);
      csr_access(1'b1, DEC_ADDR, word);
   endtask

   // Drop valid, wait for every predicted output, then let a sample or tap
   // load that produces nothing finish inside the core.
   task automatic settle();
      do begin
         @(negedge clock);
         req_valid <= 1'b0;
      end while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Result sink: draw a stall per result, and honor one long hold on request.
   initial begin : result_sink
      int stall;
      forever begin
         @(negedge clock);
         if (recv_hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (recv_hold) @(negedge clock);
            recv_hold = 0;
         end
         stall = ($urandom_range(0, 99) < recv_idle_pct) ? $urandom_range(0, MAX_GAP) : 0;
         repeat (stall) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("** complex_fir_decimator_core: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int            batch;
      int            sample_bits;
      tap_shape_type shape;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ------------------------------------------------
      send_idle_pct = 30;
      recv_idle_pct = 30;
      // reset value of the factor is 1
      csr_access(1'b0, DEC_ADDR, '0);

      // Half-LSB rounding: a 0.5 tap on +1 rounds up, on -1 rounds to zero.
      push_tap(TAP_IDX_W'(0), 18'sh10000, 18'sh00000);
      push_sample(16'sh0001, 16'shffff);
      // Extreme taps at both ends of the store, then extreme samples: saturate.
      push_tap(TAP_IDX_W'(0), 18'sh1ffff, 18'sh1ffff);
      push_tap(TAP_IDX_W'(63), 18'sh20000, 18'sh20000);
      push_tap(TAP_IDX_W'(1), 18'sh20000, 18'sh1ffff);
      push_sample(16'sh7fff, 16'sh8000);
      push_sample(16'sh8000, 16'sh8000);
      push_sample(16'sh7fff, 16'sh7fff);
      push_sample(16'sh0000, 16'sh0000);
      push_sample(16'sh0001, 16'shffff);

      // A zero factor behaves as one: every sample produces an output.
      settle();
      set_factor(0);
      push_sample(16'sh1234, 16'shedcb);
      push_sample(16'sh8000, 16'sh7fff);

      // Writes above the last register are dropped; read back to confirm.
      settle();
      csr_access(1'b1, SPARE_ADDR, 32'h0000_0005);
      csr_access(1'b0, DEC_ADDR, '0);

      // Lower the factor mid-count: three samples into a period of five, a
      // factor of two must fire on the very next sample.
      set_factor(5);
      push_sample(16'sh0100, 16'sh0200);
      push_sample(16'shff00, 16'sh0300);
      push_sample(16'sh4000, 16'shc000);
      settle();
      set_factor(2);
      push_sample(16'sh0010, 16'shfff0);
      push_sample(16'sh7fff, 16'sh0001);
      push_sample(16'sh8000, 16'sh0002);

      // ---- back-pressure: hold the sink long enough to stall the input ----
      settle();
      set_factor(1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold     = HOLD_CYCLES;
      repeat (12) push_sample(SAMPLE_W'(rand_signed(SAMPLE_W)), SAMPLE_W'(rand_signed(SAMPLE_W)));

      // ---- random part: one factor per phase, sender paused between -------
      while (items_sent < ITEM_TARGET) begin
         settle();
         case ($urandom_range(0, 11))
            0:       set_factor(0);
            1:       set_factor(DEC_MAX);
            2:       set_factor($urandom_range(DEC_MAX + 1, 127));
            3:       set_factor($urandom_range(0, 127));
            4:       set_factor($urandom_range(9, 32));
            default: set_factor($urandom_range(1, 8));
         endcase
         if ($urandom_range(0, 7) == 0)
            csr_access(1'b1, SPARE_ADDR, $urandom());
         if ($urandom_range(0, 3) == 0)
            csr_access(1'b0, DEC_ADDR, '0);

         // include phases with no idling on either side
         case ($urandom_range(0, 2))
            0:       send_idle_pct = 0;
            1:       send_idle_pct = 25;
            default: send_idle_pct = 80;
         endcase
         case ($urandom_range(0, 2))
            0:       recv_idle_pct = 0;
            1:       recv_idle_pct = 25;
            default: recv_idle_pct = 80;
         endcase

         // Reload the whole tap store in a third of the phases; small taps keep
         // most outputs in range, full-scale taps clip most of them.
         if ($urandom_range(0, 2) == 0) begin
            shape = tap_shape_type'($urandom_range(0, 2));
            for (int i = 0; i < FIR_TAPS; i++)
               push_tap(TAP_IDX_W'(i), pick_tap(shape), pick_tap(shape));
         end

         sample_bits = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : SAMPLE_W;
         batch       = $urandom_range(40, 160);
         repeat (batch) begin
            if ($urandom_range(0, 19) == 0)
               push_tap(TAP_IDX_W'($urandom()), pick_tap(TAPS_FULL), pick_tap(TAPS_SMALL));
            else
               push_sample(SAMPLE_W'(rand_signed(sample_bits)),
                           SAMPLE_W'(rand_signed(sample_bits)));
         end
      end

      // ---- wind down and report ----------------------------------------
      settle();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("** complex_fir_decimator_core: PASSED **");
      end else begin
         $display("** complex_fir_decimator_core: FAILED **");
      end
      $finish;
   end

endmodule
